// ----- hw/rtl/cbw_pkg.sv -----
// Shared types, codes and constants for the character LCD bus write sequencer.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package cbw_pkg;

  // Command codes carried on the func field.
  typedef enum logic [2:0] {
    FUNC_INSTR = 3'd0,
    FUNC_CHAR  = 3'd1,
    FUNC_DDRAM = 3'd2,
    FUNC_CGRAM = 3'd3,
    FUNC_GOTO  = 3'd4
  } func_t;

  // Configuration register indexes (byte address = 4 * index).
  typedef enum logic [1:0] {
    REG_BUS_MODE    = 2'd0,
    REG_ENABLE_HOLD = 2'd1,
    REG_NIBBLE_GAP  = 2'd2,
    REG_SETTLE      = 2'd3
  } reg_idx_t;

  // Bus-state sequencer steps. Eight-bit transfers skip STEP_FIRST_LOW.
  typedef enum logic [1:0] {
    STEP_FIRST_HIGH  = 2'd0,
    STEP_FIRST_LOW   = 2'd1,
    STEP_SECOND_HIGH = 2'd2,
    STEP_SECOND_LOW  = 2'd3
  } step_t;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int HOLD_W  = 21;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  DDRAM_CMD      = 8'h80;
  localparam logic [7:0]  CGRAM_CMD      = 8'h40;
  localparam logic [7:0]  DDRAM_MASK     = 8'h7F;
  localparam logic [7:0]  CGRAM_MASK     = 8'h3F;
  localparam logic [6:0]  LOWER_ROW_BASE = 7'h40;
  localparam logic [19:0] GAP_MAX        = 20'd1000000;

  localparam logic        RST_BUS_MODE    = 1'b0;
  localparam logic [15:0] RST_ENABLE_HOLD = 16'd1000;
  localparam logic [19:0] RST_NIBBLE_GAP  = 20'd100000;
  localparam logic [15:0] RST_SETTLE      = 16'd50;

  // One classified command waiting for the bus sequencer.
  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       rs;
    logic       instr;
    logic       addr;
  } entry_t;

  // Configuration as the sequencer sees it; the gap is already clamped.
  typedef struct packed {
    logic        bus_mode;
    logic [15:0] enable_hold;
    logic [19:0] gap_sat;
    logic [15:0] settle;
  } cfg_t;

endpackage

// ----- hw/rtl/cbw_regs.sv -----
// Configuration register file with an APB-style access port.
// Depends on cbw_pkg for register indexes, reset values and cfg_t.
module cbw_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbw_pkg::PADDR_W-1:0]  paddr,
  input  logic [cbw_pkg::PDATA_W-1:0]  pwdata,
  output logic [cbw_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output cbw_pkg::cfg_t                cfg
);

  logic        bus_mode;
  logic [15:0] enable_hold;
  logic [19:0] nibble_gap;
  logic [15:0] settle;
  logic        wr_en;
  cbw_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = cbw_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_mode    <= cbw_pkg::RST_BUS_MODE;
      enable_hold <= cbw_pkg::RST_ENABLE_HOLD;
      nibble_gap  <= cbw_pkg::RST_NIBBLE_GAP;
      settle      <= cbw_pkg::RST_SETTLE;
    end else if (wr_en) begin
      unique case (idx)
        cbw_pkg::REG_BUS_MODE:    bus_mode    <= pwdata[0];
        cbw_pkg::REG_ENABLE_HOLD: enable_hold <= pwdata[15:0];
        cbw_pkg::REG_NIBBLE_GAP:  nibble_gap  <= pwdata[19:0];
        cbw_pkg::REG_SETTLE:      settle      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      cbw_pkg::REG_BUS_MODE:    prdata = {31'd0, bus_mode};
      cbw_pkg::REG_ENABLE_HOLD: prdata = {16'd0, enable_hold};
      cbw_pkg::REG_NIBBLE_GAP:  prdata = {12'd0, nibble_gap};
      cbw_pkg::REG_SETTLE:      prdata = {16'd0, settle};
      default:                  prdata = '0;
    endcase
  end

  // Gap values above the limit are clamped for use, but read back as written.
  always_comb begin
    cfg.bus_mode    = bus_mode;
    cfg.enable_hold = enable_hold;
    cfg.gap_sat     = (nibble_gap > cbw_pkg::GAP_MAX) ? cbw_pkg::GAP_MAX : nibble_gap;
    cfg.settle      = settle;
  end

endmodule

// ----- hw/rtl/cbw_front.sv -----
// Command front end: accepts command beats and turns them into queue entries.
// Depends on cbw_pkg for the func codes, address constants and entry_t.
module cbw_front (
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  logic [2:0]       func,
  input  logic [7:0]       value,
  input  logic             row,
  input  logic [5:0]       col,
  input  logic             q_full,
  output logic             push,
  output cbw_pkg::entry_t  entry
);

  logic       known;
  logic [6:0] pos;

  assign cmd_ready = !q_full;

  // Cursor position in DDRAM form; the lower row starts at 0x40.
  assign pos = {1'b0, col} + (row ? cbw_pkg::LOWER_ROW_BASE : 7'd0);

  always_comb begin
    known          = 1'b1;
    entry.cmd_byte = value;
    entry.rs       = 1'b0;
    entry.instr    = 1'b1;
    entry.addr     = 1'b0;
    unique case (cbw_pkg::func_t'(func))
      cbw_pkg::FUNC_INSTR: entry.cmd_byte = value;
      cbw_pkg::FUNC_CHAR: begin
        entry.rs    = 1'b1;
        entry.instr = 1'b0;
      end
      cbw_pkg::FUNC_DDRAM: begin
        entry.cmd_byte = cbw_pkg::DDRAM_CMD | (value & cbw_pkg::DDRAM_MASK);
        entry.addr     = 1'b1;
      end
      cbw_pkg::FUNC_CGRAM: begin
        entry.cmd_byte = cbw_pkg::CGRAM_CMD | (value & cbw_pkg::CGRAM_MASK);
        entry.addr     = 1'b1;
      end
      cbw_pkg::FUNC_GOTO: begin
        entry.cmd_byte = cbw_pkg::DDRAM_CMD | {1'b0, pos};
        entry.addr     = 1'b1;
      end
      default: known = 1'b0;
    endcase
  end

  // Unknown codes are accepted and dropped.
  assign push = cmd_valid && cmd_ready && known;

endmodule

// ----- hw/rtl/cbw_queue.sv -----
// Small FIFO of classified commands between the front end and the sequencer.
// Depends on cbw_pkg for entry_t.
module cbw_queue #(
  parameter int DEPTH = cbw_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cbw_pkg::entry_t  wr_data,
  input  logic             pop,
  output cbw_pkg::entry_t  rd_data,
  output logic             full,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cbw_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
    return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop)  rd_ptr <= wrap_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= CW'(DEPTH)) && !(push && full) && !(pop && !not_empty))
    else $error("cbw_queue: overflow or underflow");

endmodule

// ----- hw/rtl/cbw_back.sv -----
// Bus-state sequencer: plays one queued command out as three or four timed
// bus beats. Owns the data-line value. Depends on cbw_pkg for step_t, cfg_t.
module cbw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  cbw_pkg::cfg_t               cfg,
  input  logic                        head_valid,
  input  cbw_pkg::entry_t             head,
  output logic                        pop,
  output logic                        bus_valid,
  input  logic                        bus_ready,
  output logic                        register_select,
  output logic                        read_write,
  output logic                        enable,
  output logic [7:0]                  data_lines,
  output logic [cbw_pkg::HOLD_W-1:0]  hold_us,
  output logic                        last
);

  cbw_pkg::step_t step, step_next;
  logic [7:0] bus_value;
  logic       advance;
  logic       beat_en;
  logic       beat_last;
  logic [7:0] beat_data;
  logic [cbw_pkg::HOLD_W-1:0] beat_hold;
  logic [cbw_pkg::HOLD_W-1:0] eh;
  logic [cbw_pkg::HOLD_W-1:0] eh_gap;
  logic [cbw_pkg::HOLD_W-1:0] tail;
  logic [7:0] hi_data;
  logic [7:0] lo_data;

  assign eh      = cbw_pkg::HOLD_W'(cfg.enable_hold);
  assign eh_gap  = eh + cbw_pkg::HOLD_W'(cfg.gap_sat);
  assign tail    = eh + (head.instr ? cbw_pkg::HOLD_W'(cfg.settle) : '0)
                      + cbw_pkg::HOLD_W'(head.addr);
  assign hi_data = {head.cmd_byte[7:4], bus_value[3:0]};
  assign lo_data = {head.cmd_byte[3:0], bus_value[3:0]};

  assign advance = head_valid && (!bus_valid || bus_ready);
  assign pop     = advance && beat_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= cbw_pkg::STEP_FIRST_HIGH;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    step_next = step;
    beat_en   = 1'b1;
    beat_last = 1'b0;
    beat_data = hi_data;
    beat_hold = eh;
    unique case (step)
      cbw_pkg::STEP_FIRST_HIGH: begin
        beat_data = cfg.bus_mode ? bus_value : hi_data;
        step_next = cfg.bus_mode ? cbw_pkg::STEP_SECOND_HIGH : cbw_pkg::STEP_FIRST_LOW;
      end
      cbw_pkg::STEP_FIRST_LOW: begin
        beat_en   = 1'b0;
        beat_hold = head.instr ? eh_gap : eh;
        step_next = cbw_pkg::STEP_SECOND_HIGH;
      end
      cbw_pkg::STEP_SECOND_HIGH: begin
        beat_data = cfg.bus_mode ? head.cmd_byte : lo_data;
        beat_hold = cfg.bus_mode ? '0 : eh;
        step_next = cbw_pkg::STEP_SECOND_LOW;
      end
      cbw_pkg::STEP_SECOND_LOW: begin
        beat_en   = 1'b0;
        beat_last = 1'b1;
        beat_data = cfg.bus_mode ? head.cmd_byte : lo_data;
        beat_hold = tail;
        step_next = cbw_pkg::STEP_FIRST_HIGH;
      end
      default: step_next = cbw_pkg::STEP_FIRST_HIGH;
    endcase
    if (!advance) begin
      step_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_value <= '0;
      bus_valid <= 1'b0;
    end else begin
      if (pop) bus_value <= beat_data;
      if (advance) begin
        bus_valid <= 1'b1;
      end else if (bus_ready) begin
        bus_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      register_select <= head.rs;
      enable          <= beat_en;
      data_lines      <= beat_data;
      hold_us         <= beat_hold;
      last            <= beat_last;
    end
  end

  assign read_write = 1'b0;

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (step != cbw_pkg::STEP_FIRST_HIGH) |-> head_valid)
    else $error("cbw_back: command left the queue mid-sequence");

  a_bus_value_on_pop: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(pop)) |-> $stable(bus_value))
    else $error("cbw_back: data-line value changed without a finished command");

endmodule

// ----- hw/rtl/char_lcd_bus_write_sequencer_unit.sv -----
// Top level of the character LCD bus write sequencer.
// Depends on cbw_pkg and instantiates cbw_regs, cbw_front, cbw_queue, cbw_back.
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ---------------------------------------------
//  config    psel/penable/pready    pwrite, paddr[3:0], pwdata[31:0] -> prdata
//  command   cmd_valid/cmd_ready    func, value, row, col
//  bus       bus_valid/bus_ready    register_select, read_write, enable,
//                                   data_lines, hold_us, last
//
// A command yields four bus beats in four-bit mode and three in eight-bit
// mode, one beat per cycle while each beat is taken from the bus output
// register, as the bus-state sequencer steps through its beats.
// A command enters the queue the cycle after it is accepted; its first beat
// then passes the bus output register before it appears. Unknown func codes
// are accepted and dropped without any beat.
// Reset (synchronous, active high) empties the queue, restores the register
// reset values and clears the data-line value to zero.
// The front end stalls only when the queue is full; the sequencer stalls only
// when the bus output register holds a beat that has not been taken.
//
// The hold time of each beat is in microseconds; timing the bus itself is
// left to the consumer of the bus beats.
module char_lcd_bus_write_sequencer_unit #(
  parameter int QUEUE_DEPTH = cbw_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbw_pkg::PADDR_W-1:0] paddr,
  input  logic [cbw_pkg::PDATA_W-1:0] pwdata,
  output logic [cbw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // Command channel.
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  logic [2:0]                  func,
  input  logic [7:0]                  value,
  input  logic                        row,
  input  logic [5:0]                  col,
  // Bus beat channel.
  output logic                        bus_valid,
  input  logic                        bus_ready,
  output logic                        register_select,
  output logic                        read_write,
  output logic                        enable,
  output logic [7:0]                  data_lines,
  output logic [cbw_pkg::HOLD_W-1:0]  hold_us,
  output logic                        last
);

  cbw_pkg::cfg_t   cfg;
  cbw_pkg::entry_t front_entry;
  cbw_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            head_valid;

  // Register file; the sequencer reads its values live, so software must only write
  // while no command is in flight; the block itself does not enforce it.
  cbw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front end: decodes the command into the byte to send and its flags.
  cbw_front u_front (
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .func      (func),
    .value     (value),
    .row       (row),
    .col       (col),
    .q_full    (q_full),
    .push      (push),
    .entry     (front_entry)
  );

  // Decoupling queue between decode and bus sequencing.
  cbw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (front_entry),
    .pop       (pop),
    .rd_data   (head),
    .full      (q_full),
    .not_empty (head_valid)
  );

  // Back end: emits the timed bus beats for the command at the queue head
  // and keeps the data-line value that four-bit transfers partly reuse.
  cbw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .bus_valid       (bus_valid),
    .bus_ready       (bus_ready),
    .register_select (register_select),
    .read_write      (read_write),
    .enable          (enable),
    .data_lines      (data_lines),
    .hold_us         (hold_us),
    .last            (last)
  );

endmodule
